/* rtl/pbrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbrs_pkg: shared types and constants
// Field widths, operation kinds and controller command struct.
// ----------------------------------------------------------------------------
package pbrs_pkg;
  localparam int THREADS = 16;
  localparam int PRIORITY_LEVELS = 32;
  localparam int TW = $clog2(THREADS);
  localparam int LW = $clog2(PRIORITY_LEVELS);
  localparam int IDW = 4;
  localparam int PRW = 5;

  typedef enum logic [2:0] {
    KIND_DEFINE    = 3'd0,
    KIND_READY     = 3'd1,
    KIND_BLOCK     = 3'd2,
    KIND_TERMINATE = 3'd3,
    KIND_SCHEDULE  = 3'd4
  } kind_t;

  typedef struct packed {
    logic load;
    logic unlink;
    logic link;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_unlink;
    logic need_link;
  } stat_t;
endpackage

/* rtl/pbrs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbrs_datapath: ready queue storage and list update
// Holds per level FIFOs, per thread counts and links, and the level bitmap.
// ----------------------------------------------------------------------------
module pbrs_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [2:0]            in_kind,
  input  logic [pbrs_pkg::IDW-1:0] in_thread_id,
  input  logic [pbrs_pkg::PRW-1:0] in_priority_req,
  input  pbrs_pkg::cmd_t        cmd,
  output pbrs_pkg::stat_t       stat,
  output logic                  out_valid,
  output logic [3:0]            out_selected_thread,
  output logic [4:0]            out_selected_priority,
  output logic                  out_idle
);
  import pbrs_pkg::*;

  logic [PRIORITY_LEVELS-1:0] bitmap_r;
  logic [TW-1:0] head_r [PRIORITY_LEVELS];
  logic [TW-1:0] tail_r [PRIORITY_LEVELS];
  logic [TW-1:0] next_r [THREADS];
  logic [TW-1:0] prev_r [THREADS];
  logic [LW-1:0] tlevel_r [THREADS];
  logic [7:0]    count_r [THREADS];
  logic [TW-1:0] current_r;

  logic [2:0]    kind_r;
  logic [TW-1:0] t_r;
  logic [LW-1:0] pr_r;
  logic          noop_r;
  logic          sched_idle_r;

  logic          sel_found;
  logic [LW-1:0] sel_lv;
  always_comb begin
    sel_found = 1'b0;
    sel_lv = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (bitmap_r[i]) begin
        sel_found = 1'b1;
        sel_lv = LW'(i);
      end
    end
  end

  logic [LW-1:0] lv_t;
  logic [7:0]    cnt_t;
  logic          is_head;
  logic          is_tail;
  logic          lvl_used;
  assign lv_t = tlevel_r[t_r];
  assign cnt_t = count_r[t_r];
  assign is_head = head_r[lv_t] == t_r;
  assign is_tail = tail_r[lv_t] == t_r;
  assign lvl_used = bitmap_r[lv_t];

  always_comb begin
    stat = '0;
    if (!noop_r) begin
      unique case (kind_r)
        KIND_DEFINE, KIND_TERMINATE: stat.need_unlink = cnt_t != 8'd0;
        KIND_READY: stat.need_link = cnt_t == 8'd0;
        KIND_BLOCK: stat.need_unlink = cnt_t == 8'd1;
        KIND_SCHEDULE: begin
          stat.need_unlink = !sched_idle_r && !(is_head && is_tail);
          stat.need_link = stat.need_unlink;
        end
        default: ;
      endcase
    end
  end

  logic [IDW-1:0] tid_ext;
  assign tid_ext = in_thread_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_r <= '0;
      current_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        tlevel_r[i] <= '0;
        count_r[i] <= '0;
      end
    end else begin
      out_valid <= 1'b0;
      if (cmd.load) begin
        kind_r <= in_kind;
        pr_r <= (in_priority_req >= PRW'(PRIORITY_LEVELS - 1)) ?
                LW'(PRIORITY_LEVELS - 1) : LW'(in_priority_req);
        noop_r <= (in_kind != KIND_SCHEDULE) && (32'(tid_ext) >= THREADS);
        sched_idle_r <= !sel_found;
        if (in_kind == KIND_SCHEDULE) t_r <= head_r[sel_lv];
        else t_r <= TW'(in_thread_id);
      end
      if (cmd.unlink) begin
        if (is_head && is_tail) bitmap_r[lv_t] <= 1'b0;
        else if (is_head) head_r[lv_t] <= next_r[t_r];
        else if (is_tail) tail_r[lv_t] <= prev_r[t_r];
        else begin
          next_r[prev_r[t_r]] <= next_r[t_r];
          prev_r[next_r[t_r]] <= prev_r[t_r];
        end
      end
      if (cmd.link) begin
        if (!lvl_used) begin
          head_r[lv_t] <= t_r;
          tail_r[lv_t] <= t_r;
          bitmap_r[lv_t] <= 1'b1;
        end else begin
          next_r[tail_r[lv_t]] <= t_r;
          prev_r[t_r] <= tail_r[lv_t];
          tail_r[lv_t] <= t_r;
        end
      end
      if (cmd.finish && !noop_r) begin
        unique case (kind_r)
          KIND_DEFINE: begin
            tlevel_r[t_r] <= pr_r;
            count_r[t_r] <= '0;
          end
          KIND_READY: if (cnt_t != 8'hff) count_r[t_r] <= cnt_t + 8'd1;
          KIND_BLOCK: if (cnt_t != 8'd0) count_r[t_r] <= cnt_t - 8'd1;
          KIND_TERMINATE: count_r[t_r] <= '0;
          KIND_SCHEDULE: begin
            out_valid <= 1'b1;
            if (!sched_idle_r) current_r <= t_r;
          end
          default: ;
        endcase
      end
    end
  end

  logic [LW-1:0] sched_lv_r;
  always_ff @(posedge clk) begin
    if (cmd.load) sched_lv_r <= sel_lv;
  end

  assign out_idle = sched_idle_r;
  assign out_selected_thread = sched_idle_r ? 4'd0 : 4'(t_r);
  assign out_selected_priority = sched_idle_r ? 5'd0 : 5'(sched_lv_r);

  logic unused_cur;
  assign unused_cur = ^current_r;

  a_link_unlink_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.link && cmd.unlink)) else $error("link and unlink together");
  a_link_after_unlink: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.unlink && kind_r == KIND_SCHEDULE |=> cmd.link)
    else $error("rotate missing relink");
  a_valid_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held");
endmodule

/* rtl/pbrs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbrs_ctrl: operation sequencer
// Steps load, decide, optional unlink, optional link and finish for each accepted item.
// ----------------------------------------------------------------------------
module pbrs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  pbrs_pkg::stat_t stat,
  output pbrs_pkg::cmd_t  cmd
);
  import pbrs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_UNLINK, S_LINK, S_FINISH} state_t;
  state_t state_r;

  assign busy = state_r != S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.load = state_r == S_IDLE && start;
    cmd.unlink = state_r == S_UNLINK;
    cmd.link = state_r == S_LINK;
    cmd.finish = state_r == S_FINISH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (start) state_r <= S_DECIDE;
        S_DECIDE: begin
          if (stat.need_unlink) state_r <= S_UNLINK;
          else if (stat.need_link) state_r <= S_LINK;
          else state_r <= S_FINISH;
        end
        S_UNLINK: state_r <= stat.need_link ? S_LINK : S_FINISH;
        S_LINK: state_r <= S_FINISH;
        S_FINISH: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/priority_bitmap_ready_scheduler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_bitmap_ready_scheduler_unit: bitmap ready-queue scheduler
// Usage: raise start with in_kind, in_thread_id and in_priority_req while
// busy is low; the command transfers at that edge and busy rises.
// Kinds: define priority, ready, block, terminate, schedule.
// Only schedule gives a result: out_valid is high for one cycle with
// out_selected_thread, out_selected_priority and out_idle.
// An item steps through load, decide, optional unlink, optional
// link and finish. Schedule rotating a thread takes every step; the sequencer steps
// one list update per cycle through a shared link/unlink path.
// The result strobe is high in the cycle after finish, when busy is low.
// The receiver cannot stall; results are never held.
// Reset (rst_n low, synchronous) clears the level bitmap, counts,
// thread levels and current thread; list links need no clearing.
// ----------------------------------------------------------------------------
module priority_bitmap_ready_scheduler_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_kind,
  input  logic [3:0] in_thread_id,
  input  logic [4:0] in_priority_req,
  output logic       out_valid,
  output logic [3:0] out_selected_thread,
  output logic [4:0] out_selected_priority,
  output logic       out_idle
);
  import pbrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pbrs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .stat(stat), .cmd(cmd)
  );

  pbrs_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_kind(in_kind), .in_thread_id(in_thread_id),
    .in_priority_req(in_priority_req),
    .cmd(cmd), .stat(stat),
    .out_valid(out_valid),
    .out_selected_thread(out_selected_thread),
    .out_selected_priority(out_selected_priority),
    .out_idle(out_idle)
  );
endmodule
